// ===== rtl/matrix_regfile_bank_arbiter_core_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the register-file bank arbiter.
// Properties are sampled on clk_i and are off while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef MATRIX_REGFILE_BANK_ARBITER_CORE_MACROS_SVH
`define MATRIX_REGFILE_BANK_ARBITER_CORE_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define MRBA_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// The condition must never be seen at a clock edge outside reset.
`define MRBA_ASSERT_NEVER(name, cond, msg) \
  `MRBA_ASSERT(name, !(cond), msg)

`endif

// ===== rtl/mrba_pkg.sv =====
// ----------------------------------------------------------------------------
// mrba_pkg
// Shared constants and types of the register-file bank arbiter.
// ----------------------------------------------------------------------------
package mrba_pkg;

  localparam int unsigned Lanes   = 4;
  localparam int unsigned BankW   = 2;
  localparam int unsigned ReasonW = 3;

  localparam logic [BankW-1:0] BankA = 2'd0;
  localparam logic [BankW-1:0] BankB = 2'd1;
  localparam logic [BankW-1:0] BankC = 2'd2;

  typedef enum logic [ReasonW-1:0] {
    RsNone     = 3'd0,
    RsPartial  = 3'd1,
    RsConflict = 3'd2,
    RsWrPrio   = 3'd3,
    RsCRw      = 3'd4
  } reason_e;

  // What one lane found out about its own request.
  typedef struct packed {
    logic partial;
    logic in_a;
    logic in_b;
    logic in_c;
    logic wr;
    logic odd;
  } lane_info_t;

endpackage

// ===== rtl/mrba_lane.sv =====
// ----------------------------------------------------------------------------
// mrba_lane
// Decodes one lane's request: mask check and bank selection.
// ----------------------------------------------------------------------------
module mrba_lane
  import mrba_pkg::*;
(
  input  logic             valid_i,
  input  logic [BankW-1:0] bank_i,
  input  logic             write_i,
  input  logic             odd_i,
  input  logic             full_i,
  output lane_info_t       info_o
);

  logic elig;

  assign elig = valid_i & full_i;

  always_comb begin
    info_o.partial = valid_i & ~full_i;
    info_o.in_a    = elig && (bank_i == BankA);
    info_o.in_b    = elig && (bank_i == BankB);
    // Bank code three names no bank and drops out here.
    info_o.in_c    = elig && (bank_i == BankC);
    info_o.wr      = write_i;
    info_o.odd     = odd_i;
  end

endmodule

// ===== rtl/mrba_merge.sv =====
// ----------------------------------------------------------------------------
// mrba_merge
// Combines the lane decodes into per-bank arbitration, grants and reasons.
// ----------------------------------------------------------------------------
module mrba_merge
  import mrba_pkg::*;
(
  input  lane_info_t                   info_i [Lanes],
  output logic [Lanes-1:0]             grant_o,
  output logic [Lanes*ReasonW-1:0]     reason_o
);

  // True when any lane below idx has its bit set in v.
  function automatic logic any_below(input logic [Lanes-1:0] v, input int unsigned idx);
    logic [Lanes-1:0] m;
    m = '0;
    for (int unsigned k = 0; k < Lanes; k++) begin
      m[k] = (k < idx);
    end
    return |(v & m);
  endfunction

  logic [Lanes-1:0] wa, ra, wb, rb, wc, rc, odd;
  logic [Lanes-1:0] wc_first, rc_first;
  logic             c_multi, c_clash, w_odd, r_odd;

  always_comb begin
    for (int unsigned i = 0; i < Lanes; i++) begin
      wa[i]  = info_i[i].in_a &  info_i[i].wr;
      ra[i]  = info_i[i].in_a & ~info_i[i].wr;
      wb[i]  = info_i[i].in_b &  info_i[i].wr;
      rb[i]  = info_i[i].in_b & ~info_i[i].wr;
      wc[i]  = info_i[i].in_c &  info_i[i].wr;
      rc[i]  = info_i[i].in_c & ~info_i[i].wr;
      odd[i] = info_i[i].odd;
    end
    for (int unsigned i = 0; i < Lanes; i++) begin
      wc_first[i] = wc[i] & ~any_below(wc, i);
      rc_first[i] = rc[i] & ~any_below(rc, i);
    end
    c_multi = |(wc & ~wc_first);
    w_odd   = |(wc_first & odd);
    r_odd   = |(rc_first & odd);
    // The first bank C read meets the granted write on the same parity.
    c_clash = (|wc) && (|rc) && (w_odd == r_odd);
  end

  always_comb begin
    reason_e r;
    logic    g;
    for (int unsigned i = 0; i < Lanes; i++) begin
      r = RsNone;
      g = 1'b0;
      if (info_i[i].partial) begin
        r = RsPartial;
      end else if (wa[i]) begin
        if (any_below(wa, i)) r = RsConflict; else g = 1'b1;
      end else if (ra[i]) begin
        if (|wa) r = RsWrPrio;
        else if (any_below(ra, i)) r = RsConflict;
        else g = 1'b1;
      end else if (wb[i]) begin
        if (any_below(wb, i)) r = RsConflict; else g = 1'b1;
      end else if (rb[i]) begin
        if (|wb) r = RsWrPrio;
        else if (any_below(rb, i)) r = RsConflict;
        else g = 1'b1;
      end else if (wc[i]) begin
        if (!wc_first[i]) r = RsConflict;
        else if (c_clash && !c_multi) r = RsCRw;
        else g = 1'b1;
      end else if (rc[i]) begin
        if (!rc_first[i]) r = RsConflict;
        else if (c_clash) r = RsCRw;
        else if (c_multi) r = RsConflict;
        else g = 1'b1;
      end
      grant_o[i] = g;
      reason_o[i*ReasonW +: ReasonW] = r;
    end
  end

endmodule

// ===== rtl/matrix_regfile_bank_arbiter_core.sv =====
// Lane decode and merge are combinational; results are registered at the output.
// Throughput: one request set per cycle while in_stall_o is low.
// A two-entry output stage (output register plus skid register) keeps input
// accepted while one result waits under out_stall_i.
// Reset (rst_ni low, asynchronous) empties both output entries; no other state.
// ----------------------------------------------------------------------------
// matrix_regfile_bank_arbiter_core
// Register-file bank arbiter: per-lane decode, merge, and a skid output stage.
// ----------------------------------------------------------------------------
`include "matrix_regfile_bank_arbiter_core_macros.svh"

module matrix_regfile_bank_arbiter_core
  import mrba_pkg::*;
(
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [Lanes-1:0]           req_valid_i,
  input  logic [Lanes*BankW-1:0]     req_bank_i,
  input  logic [Lanes-1:0]           req_write_i,
  input  logic [Lanes-1:0]           req_entry_odd_i,
  input  logic [Lanes-1:0]           req_full_mask_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [Lanes-1:0]           grant_o,
  output logic [Lanes*ReasonW-1:0]   stall_reason_o
);

  lane_info_t                 info [Lanes];
  logic [Lanes-1:0]           res_grant;
  logic [Lanes*ReasonW-1:0]   res_reason;
  logic [Lanes-1:0]           reason_nz;

  logic                       out_valid_q, out_valid_d;
  logic                       skid_valid_q, skid_valid_d;
  logic [Lanes-1:0]           out_grant_q, out_grant_d, skid_grant_q, skid_grant_d;
  logic [Lanes*ReasonW-1:0]   out_reason_q, out_reason_d, skid_reason_q, skid_reason_d;
  logic                       accept_in, out_free;

  for (genvar i = 0; i < Lanes; i++) begin : g_lane
    mrba_lane u_lane (
      .valid_i (req_valid_i[i]),
      .bank_i  (req_bank_i[i*BankW +: BankW]),
      .write_i (req_write_i[i]),
      .odd_i   (req_entry_odd_i[i]),
      .full_i  (req_full_mask_i[i]),
      .info_o  (info[i])
    );
  end

  mrba_merge u_merge (
    .info_i   (info),
    .grant_o  (res_grant),
    .reason_o (res_reason)
  );

  always_comb begin
    for (int unsigned i = 0; i < Lanes; i++) begin
      reason_nz[i] = |res_reason[i*ReasonW +: ReasonW];
    end
  end

  // The skid entry only fills while the output entry is held, so a full
  // skid entry is the only thing that stops input beats.
  assign in_stall_o = skid_valid_q;
  assign accept_in  = in_valid_i & ~skid_valid_q;
  assign out_free   = ~out_valid_q | ~out_stall_i;

  always_comb begin
    out_valid_d   = out_valid_q;
    out_grant_d   = out_grant_q;
    out_reason_d  = out_reason_q;
    skid_valid_d  = skid_valid_q;
    skid_grant_d  = skid_grant_q;
    skid_reason_d = skid_reason_q;
    if (out_free) begin
      if (skid_valid_q) begin
        out_valid_d  = 1'b1;
        out_grant_d  = skid_grant_q;
        out_reason_d = skid_reason_q;
        skid_valid_d = 1'b0;
      end else begin
        out_valid_d  = accept_in;
        out_grant_d  = res_grant;
        out_reason_d = res_reason;
      end
    end else if (accept_in) begin
      skid_valid_d  = 1'b1;
      skid_grant_d  = res_grant;
      skid_reason_d = res_reason;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_grant_q   <= out_grant_d;
    out_reason_q  <= out_reason_d;
    skid_grant_q  <= skid_grant_d;
    skid_reason_q <= skid_reason_d;
  end

  assign out_valid_o    = out_valid_q;
  assign grant_o        = out_grant_q;
  assign stall_reason_o = out_reason_q;

  `MRBA_ASSERT_NEVER(a_skid_without_out, skid_valid_q && !out_valid_q, "skid full, output empty")
  `MRBA_ASSERT(a_skid_fill, $rose(skid_valid_q) |-> $past(out_valid_q && out_stall_i), "skid fill")
  `MRBA_ASSERT_NEVER(a_grant_reason, (res_grant & reason_nz) != '0, "granted lane has a stall reason")

endmodule
